// ===== rtl/qrm_pkg.sv =====
package qrm_pkg;

  // Q2.14 fixed point
  localparam int FRAC_BITS = 14;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  // norm squared reaches 2^32, so 33 bits unsigned
  localparam int DEN_W = 33;
  // quotient bits of 2*|num|*2^14/nq, one spare bit for rounding
  localparam int QB = FRAC_BITS + 2;
  localparam int NUM_W = 36;
  localparam int LANES = 9;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_norm;
  } out_t;

  // word handed from front to back through the queue
  typedef struct packed {
    logic                              zero;
    logic [DEN_W-1:0]                  den;
    logic [LANES-1:0]                  neg;
    logic [LANES-1:0][DEN_W-1:0]       mag;
  } qword_t;

  // one stage of the divider pipeline
  typedef struct packed {
    logic                              zero;
    logic [DEN_W-1:0]                  den;
    logic [LANES-1:0]                  neg;
    logic [LANES-1:0][DEN_W-1:0]       rem;
    logic [LANES-1:0][QB-1:0]          quo;
  } dstage_t;

endpackage

// ===== rtl/qrm_front.sv =====
module qrm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qrm_pkg::in_t  in_word,
  input  logic          q_full,
  output logic          q_push,
  output qrm_pkg::qword_t q_word
);
  import qrm_pkg::*;

  typedef struct packed {
    logic signed [31:0] xx, yy, zz, ww;
    logic signed [31:0] xy, xz, xw, yz, yw, zw;
  } prod_t;

  prod_t p_r;
  logic  v1_r;
  qword_t w2_r;
  logic  v2_r;
  logic  adv1, adv2;
  prod_t p_nxt;
  qword_t w2_nxt;

  logic signed [NUM_W-1:0] nq;
  logic signed [NUM_W-1:0] num [LANES];

  assign q_push   = v2_r && !q_full;
  assign adv2     = !v2_r || !q_full;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign q_word   = w2_r;

  // stage 1: pairwise products
  always_comb begin
    p_nxt.xx = 32'(in_word.quat_x) * 32'(in_word.quat_x);
    p_nxt.yy = 32'(in_word.quat_y) * 32'(in_word.quat_y);
    p_nxt.zz = 32'(in_word.quat_z) * 32'(in_word.quat_z);
    p_nxt.ww = 32'(in_word.quat_w) * 32'(in_word.quat_w);
    p_nxt.xy = 32'(in_word.quat_x) * 32'(in_word.quat_y);
    p_nxt.xz = 32'(in_word.quat_x) * 32'(in_word.quat_z);
    p_nxt.xw = 32'(in_word.quat_x) * 32'(in_word.quat_w);
    p_nxt.yz = 32'(in_word.quat_y) * 32'(in_word.quat_z);
    p_nxt.yw = 32'(in_word.quat_y) * 32'(in_word.quat_w);
    p_nxt.zw = 32'(in_word.quat_z) * 32'(in_word.quat_w);
  end

  // stage 2: norm, numerators, sign/magnitude split, zero check
  always_comb begin
    nq = NUM_W'(p_r.xx) + NUM_W'(p_r.yy) + NUM_W'(p_r.zz) + NUM_W'(p_r.ww);
    num[0] = nq - ((NUM_W'(p_r.yy) + NUM_W'(p_r.zz)) <<< 1);
    num[1] = (NUM_W'(p_r.xy) - NUM_W'(p_r.zw)) <<< 1;
    num[2] = (NUM_W'(p_r.xz) + NUM_W'(p_r.yw)) <<< 1;
    num[3] = (NUM_W'(p_r.xy) + NUM_W'(p_r.zw)) <<< 1;
    num[4] = nq - ((NUM_W'(p_r.xx) + NUM_W'(p_r.zz)) <<< 1);
    num[5] = (NUM_W'(p_r.yz) - NUM_W'(p_r.xw)) <<< 1;
    num[6] = (NUM_W'(p_r.xz) - NUM_W'(p_r.yw)) <<< 1;
    num[7] = (NUM_W'(p_r.yz) + NUM_W'(p_r.xw)) <<< 1;
    num[8] = nq - ((NUM_W'(p_r.xx) + NUM_W'(p_r.yy)) <<< 1);
    w2_nxt.zero = (nq == '0);
    w2_nxt.den  = nq[DEN_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      w2_nxt.neg[l] = num[l][NUM_W-1];
      w2_nxt.mag[l] = num[l][NUM_W-1] ? DEN_W'(-num[l]) : num[l][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) p_r  <= p_nxt;
    if (adv2) w2_r <= w2_nxt;
  end

endmodule

// ===== rtl/qrm_fifo.sv =====
module qrm_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  qrm_pkg::qword_t wr_word,
  output logic            full,
  input  logic            pop,
  output qrm_pkg::qword_t rd_word,
  output logic            empty
);
  import qrm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qword_t          mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_word = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_word;
  end

  // pointers wrap at DEPTH-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/qrm_back.sv =====
module qrm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  qrm_pkg::qword_t q_word,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output qrm_pkg::out_t   out_word
);
  import qrm_pkg::*;

  dstage_t         st_r   [QB];
  dstage_t         st_nxt [QB];
  dstage_t         src    [QB];
  logic [QB-1:0]   vld_r;
  logic            out_valid_r;
  out_t            out_r;
  out_t            out_nxt;
  logic            adv;
  logic signed [15:0] ent [LANES];

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // queue word enters with the magnitude as the starting remainder
  always_comb begin
    src[0].zero = q_word.zero;
    src[0].den  = q_word.den;
    src[0].neg  = q_word.neg;
    src[0].rem  = q_word.mag;
    src[0].quo  = '0;
  end

  // one restoring division step per stage, nine lanes in parallel
  for (genvar s = 0; s < QB; s++) begin : g_stage
    if (s > 0) begin : g_src
      assign src[s] = st_r[s-1];
    end
    always_comb begin
      logic [DEN_W:0] t;
      logic           ge;
      st_nxt[s] = src[s];
      for (int l = 0; l < LANES; l++) begin
        t  = (s == 0) ? {1'b0, src[s].rem[l]} : {src[s].rem[l], 1'b0};
        ge = (t >= {1'b0, src[s].den});
        if (ge) t = t - {1'b0, src[s].den};
        st_nxt[s].rem[l] = t[DEN_W-1:0];
        st_nxt[s].quo[l] = {src[s].quo[l][QB-2:0], ge};
      end
    end
  end

  // round half away from zero, restore sign, identity on zero norm
  always_comb begin
    logic [QB:0] q;
    for (int l = 0; l < LANES; l++) begin
      q = ({1'b0, st_r[QB-1].quo[l]} + 1'b1) >> 1;
      ent[l] = st_r[QB-1].neg[l] ? -$signed(q[15:0]) : $signed(q[15:0]);
    end
    if (st_r[QB-1].zero) begin
      out_nxt = '0;
      out_nxt.m00 = ONE_Q14;
      out_nxt.m11 = ONE_Q14;
      out_nxt.m22 = ONE_Q14;
      out_nxt.zero_norm = 1'b1;
    end else begin
      out_nxt.m00 = ent[0];
      out_nxt.m01 = ent[1];
      out_nxt.m02 = ent[2];
      out_nxt.m10 = ent[3];
      out_nxt.m11 = ent[4];
      out_nxt.m12 = ent[5];
      out_nxt.m20 = ent[6];
      out_nxt.m21 = ent[7];
      out_nxt.m22 = ent[8];
      out_nxt.zero_norm = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[QB-2:0], !q_empty};
      out_valid_r <= vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < QB; s++) st_r[s] <= st_nxt[s];
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/quaternion_to_rotation_matrix_top.sv =====
// Quaternion (x, y, z, w, signed Q2.14, any length) to 3x3 rotation matrix in
// signed Q2.14, row-major, each entry rounded to nearest with halves away from
// zero; an all-zero quaternion gives the identity with zero_norm set. While
// out_ready is held high, one word is taken per cycle and one result word
// leaves per cycle. On an idle path a word passes through two front stages
// for the products and numerators, the queue, sixteen restoring divider
// stages (one quotient bit each, nine lanes sharing the norm as divisor) and
// the output register. The queue, QDEPTH words deep, lets the front keep
// taking words while the output stalls.
module quaternion_to_rotation_matrix_top #(
  parameter int QDEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qrm_pkg::in_t   in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output qrm_pkg::out_t  out_word
);
  import qrm_pkg::*;

  qword_t fw, bw;
  logic   q_push, q_full, q_pop, q_empty;

  qrm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (fw)
  );

  qrm_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_word (fw),
    .full    (q_full),
    .pop     (q_pop),
    .rd_word (bw),
    .empty   (q_empty)
  );

  qrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_word    (bw),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue pop while empty");

  // zero norm result is the identity
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zero_norm |->
      out_word.m00 == ONE_Q14 && out_word.m11 == ONE_Q14 &&
      out_word.m22 == ONE_Q14 && out_word.m01 == '0 && out_word.m12 == '0)
    else $error("zero norm result is not identity");

endmodule
